@@ design/gmcn_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid menu cursor navigator package
// Shared widths, defaults, codes, configuration and command types.
// ----------------------------------------------------------------------------
package gmcn_pkg;

  localparam int OP_W     = 4;
  localparam int NUM_W    = 8;
  localparam int DIM_W    = 4;
  localparam int MODE_W   = 2;
  localparam int CODE_W   = 2;
  localparam int ITEM_W   = 7;
  localparam int IDX_W    = 7;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // One quotient bit per divider step, so one step per bit of item_number.
  localparam int DIV_STEPS = NUM_W;

  localparam int MAX_COLUMNS_DEF = 9;
  localparam int MAX_ROWS_DEF    = 9;
  localparam int DIRECT_KEYS_DEF = 10;

  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_LEFT    = 4'd1;
  localparam logic [OP_W-1:0] OP_RIGHT   = 4'd2;
  localparam logic [OP_W-1:0] OP_UP      = 4'd3;
  localparam logic [OP_W-1:0] OP_DOWN    = 4'd4;
  localparam logic [OP_W-1:0] OP_CONFIRM = 4'd5;
  localparam logic [OP_W-1:0] OP_ABORT   = 4'd6;
  localparam logic [OP_W-1:0] OP_PICK    = 4'd7;
  localparam logic [OP_W-1:0] OP_JUMP    = 4'd8;

  localparam logic [MODE_W-1:0] SCR_STOP       = 2'd0;
  localparam logic [MODE_W-1:0] SCR_WRAP       = 2'd1;
  localparam logic [MODE_W-1:0] SCR_CARRY      = 2'd2;
  localparam logic [MODE_W-1:0] SCR_CARRY_WRAP = 2'd3;

  localparam logic [CODE_W-1:0] RC_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] RC_ABORT  = 2'd1;
  localparam logic [CODE_W-1:0] RC_CHOSEN = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]  columns;
    logic [DIM_W-1:0]  rows;
    logic [MODE_W-1:0] scroll_mode;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic finish;
  } cmd_t;

endpackage

@@ design/gmcn_channels.sv @@
// ----------------------------------------------------------------------------
// Grid menu cursor navigator channels
// Valid/ready interfaces for the key request and result channels.
// ----------------------------------------------------------------------------
interface gmcn_in_if;
  logic                       valid;
  logic                       ready;
  logic [gmcn_pkg::OP_W-1:0]  operation;
  logic [gmcn_pkg::NUM_W-1:0] item_number;

  modport source (output valid, output operation, output item_number, input ready);
  modport sink   (input valid, input operation, input item_number, output ready);
endinterface

interface gmcn_out_if;
  logic                        valid;
  logic                        ready;
  logic [gmcn_pkg::CODE_W-1:0] result_code;
  logic [gmcn_pkg::ITEM_W-1:0] chosen_item;
  logic [gmcn_pkg::IDX_W-1:0]  cursor_index;
  logic [gmcn_pkg::DIM_W-1:0]  cursor_column;
  logic [gmcn_pkg::DIM_W-1:0]  cursor_row;

  modport source (output valid, output result_code, output chosen_item,
                  output cursor_index, output cursor_column, output cursor_row,
                  input ready);
  modport sink   (input valid, input result_code, input chosen_item,
                  input cursor_index, input cursor_column, input cursor_row,
                  output ready);
endinterface

@@ design/gmcn_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Grid menu cursor navigator configuration registers
// APB-style register file holding grid size and scroll mode.
// ----------------------------------------------------------------------------
module gmcn_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmcn_pkg::APB_AW-1:0]   paddr,
  input  logic [gmcn_pkg::APB_DW-1:0]   pwdata,
  output logic [gmcn_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output gmcn_pkg::cfg_t                cfg
);

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_SCROLL  = 2'd2;

  gmcn_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns     <= gmcn_pkg::DIM_W'(1);
      cfg_r.rows        <= gmcn_pkg::DIM_W'(1);
      cfg_r.scroll_mode <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_COLUMNS: cfg_r.columns     <= pwdata[gmcn_pkg::DIM_W-1:0];
        REG_ROWS:    cfg_r.rows        <= pwdata[gmcn_pkg::DIM_W-1:0];
        REG_SCROLL:  cfg_r.scroll_mode <= pwdata[gmcn_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_COLUMNS: prdata[gmcn_pkg::DIM_W-1:0]  = cfg_r.columns;
      REG_ROWS:    prdata[gmcn_pkg::DIM_W-1:0]  = cfg_r.rows;
      REG_SCROLL:  prdata[gmcn_pkg::MODE_W-1:0] = cfg_r.scroll_mode;
      default:     prdata = '0;
    endcase
  end

endmodule

@@ design/gmcn_ctrl.sv @@
// ----------------------------------------------------------------------------
// Grid menu cursor navigator controller
// Sequences request acceptance, the divider steps, the update and the result.
// ----------------------------------------------------------------------------
module gmcn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output gmcn_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(gmcn_pkg::DIV_STEPS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.finish   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(gmcn_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ design/gmcn_datapath.sv @@
// ----------------------------------------------------------------------------
// Grid menu cursor navigator datapath
// Cursor registers, bit-serial divider by the column count, and result logic.
// ----------------------------------------------------------------------------
module gmcn_datapath #(
  parameter int MAX_COLUMNS = gmcn_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gmcn_pkg::MAX_ROWS_DEF,
  parameter int DIRECT_KEYS = gmcn_pkg::DIRECT_KEYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gmcn_pkg::cfg_t               cfg,
  input  gmcn_pkg::cmd_t               cmd,
  input  logic [gmcn_pkg::OP_W-1:0]    operation,
  input  logic [gmcn_pkg::NUM_W-1:0]   item_number,
  output logic [gmcn_pkg::CODE_W-1:0]  result_code,
  output logic [gmcn_pkg::ITEM_W-1:0]  chosen_item,
  output logic [gmcn_pkg::IDX_W-1:0]   cursor_index,
  output logic [gmcn_pkg::DIM_W-1:0]   cursor_column,
  output logic [gmcn_pkg::DIM_W-1:0]   cursor_row
);

  localparam int DW = gmcn_pkg::DIM_W;
  localparam int NW = gmcn_pkg::NUM_W;
  localparam int PW = 2 * DW;

  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v,
                                            input logic [DW-1:0] maxv);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = DW'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  logic [gmcn_pkg::OP_W-1:0]   op_r;
  logic [NW-1:0]               num_r;
  logic [NW-1:0]               dvd_r;
  logic [DW:0]                 rem_r;
  logic [DW-1:0]               col_r, row_r;
  logic [gmcn_pkg::CODE_W-1:0] code_r;
  logic [gmcn_pkg::ITEM_W-1:0] chosen_r;
  logic [gmcn_pkg::IDX_W-1:0]  idx_r;
  logic [DW-1:0]               ocol_r, orow_r;

  logic [DW-1:0] nc, nr, nc_m1, nr_m1, x0, y0, x, y;
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [PW-1:0] area, idx_full;
  logic [gmcn_pkg::CODE_W-1:0] code;
  logic [gmcn_pkg::ITEM_W-1:0] chosen;

  assign nc    = eff_dim(cfg.columns, DW'(MAX_COLUMNS));
  assign nr    = eff_dim(cfg.rows, DW'(MAX_ROWS));
  assign nc_m1 = nc - DW'(1);
  assign nr_m1 = nr - DW'(1);
  assign x0    = (col_r > nc_m1) ? nc_m1 : col_r;
  assign y0    = (row_r > nr_m1) ? nr_m1 : row_r;
  assign area  = PW'(nc) * PW'(nr);

  assign rem_sh = {rem_r[DW-1:0], dvd_r[NW-1]};
  assign rem_ge = (rem_sh >= {1'b0, nc});

  always_comb begin
    x      = x0;
    y      = y0;
    code   = gmcn_pkg::RC_NONE;
    chosen = '0;
    case (op_r)
      gmcn_pkg::OP_LEFT: begin
        if (x0 != '0) begin
          x = x0 - DW'(1);
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_WRAP) begin
          x = nc_m1;
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY) begin
          if (y0 != '0) begin
            x = nc_m1;
            y = y0 - DW'(1);
          end
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY_WRAP) begin
          x = nc_m1;
          y = (y0 != '0) ? y0 - DW'(1) : nr_m1;
        end
      end
      gmcn_pkg::OP_RIGHT: begin
        if (x0 < nc_m1) begin
          x = x0 + DW'(1);
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_WRAP) begin
          x = '0;
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY) begin
          if (y0 < nr_m1) begin
            x = '0;
            y = y0 + DW'(1);
          end
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY_WRAP) begin
          x = '0;
          y = (y0 < nr_m1) ? y0 + DW'(1) : '0;
        end
      end
      gmcn_pkg::OP_UP: begin
        if (y0 != '0) begin
          y = y0 - DW'(1);
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_WRAP) begin
          y = nr_m1;
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY) begin
          if (x0 != '0) begin
            y = nr_m1;
            x = x0 - DW'(1);
          end
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY_WRAP) begin
          y = nr_m1;
          x = (x0 != '0) ? x0 - DW'(1) : nc_m1;
        end
      end
      gmcn_pkg::OP_DOWN: begin
        if (y0 < nr_m1) begin
          y = y0 + DW'(1);
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_WRAP) begin
          y = '0;
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY) begin
          if (x0 < nc_m1) begin
            y = '0;
            x = x0 + DW'(1);
          end
        end else if (cfg.scroll_mode == gmcn_pkg::SCR_CARRY_WRAP) begin
          y = '0;
          x = (x0 < nc_m1) ? x0 + DW'(1) : '0;
        end
      end
      gmcn_pkg::OP_CONFIRM: begin
        code = gmcn_pkg::RC_CHOSEN;
      end
      gmcn_pkg::OP_ABORT: begin
        code = gmcn_pkg::RC_ABORT;
      end
      gmcn_pkg::OP_PICK: begin
        if ((num_r != '0) && (num_r <= NW'(DIRECT_KEYS)) && (num_r <= NW'(area))) begin
          x      = rem_r[DW-1:0];
          y      = dvd_r[DW-1:0];
          code   = gmcn_pkg::RC_CHOSEN;
          chosen = num_r[gmcn_pkg::ITEM_W-1:0];
        end
      end
      gmcn_pkg::OP_JUMP: begin
        if ((num_r != '0) && (dvd_r < NW'(nr))) begin
          x = rem_r[DW-1:0];
          y = dvd_r[DW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign idx_full = PW'(y) * PW'(nc) + PW'(x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.finish) begin
      col_r <= x;
      row_r <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      num_r <= item_number;
      dvd_r <= item_number - NW'(1);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_sh - {1'b0, nc};
        dvd_r <= {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        dvd_r <= {dvd_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      code_r   <= code;
      chosen_r <= (op_r == gmcn_pkg::OP_CONFIRM) ?
                  idx_full[gmcn_pkg::ITEM_W-1:0] + gmcn_pkg::ITEM_W'(1) : chosen;
      idx_r    <= idx_full[gmcn_pkg::IDX_W-1:0];
      ocol_r   <= x;
      orow_r   <= y;
    end
  end

  assign result_code   = code_r;
  assign chosen_item   = chosen_r;
  assign cursor_index  = idx_r;
  assign cursor_column = ocol_r;
  assign cursor_row    = orow_r;

endmodule

@@ design/grid_menu_cursor_navigator.sv @@
// ----------------------------------------------------------------------------
// Grid menu cursor navigator
// An accepted key request passes through the 8-step serial divider, which
// divides item_number minus one by the column count, and a finish step; the
// result is then offered, and no new request is taken until it has been taken.
// Reset: synchronous rst_n returns the cursor to 0,0 and the grid to 1 by 1.
// ----------------------------------------------------------------------------
module grid_menu_cursor_navigator #(
  parameter int MAX_COLUMNS = gmcn_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gmcn_pkg::MAX_ROWS_DEF,
  parameter int DIRECT_KEYS = gmcn_pkg::DIRECT_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gmcn_in_if.sink                     in_ch,
  gmcn_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gmcn_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [gmcn_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [gmcn_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  gmcn_pkg::cfg_t cfg;
  gmcn_pkg::cmd_t cmd;
  logic           in_ready;
  logic           out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  gmcn_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  gmcn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  gmcn_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .DIRECT_KEYS (DIRECT_KEYS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .operation     (in_ch.operation),
    .item_number   (in_ch.item_number),
    .result_code   (out_ch.result_code),
    .chosen_item   (out_ch.chosen_item),
    .cursor_index  (out_ch.cursor_index),
    .cursor_column (out_ch.cursor_column),
    .cursor_row    (out_ch.cursor_row)
  );

endmodule

@@ tb/grid_menu_cursor_navigator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid menu cursor navigator testbench
// Sends key requests through the valid/ready channel and predicts every result
// with a cycle-free model of the cursor, the edge rules and the grid clamps.
// A directed table, part of it with the expected results typed in, comes
// first. Random phases follow, each with its own grid and scroll mode and one
// of four idling patterns. Configuration is written over APB only while idle.
// ----------------------------------------------------------------------------
module grid_menu_cursor_navigator_tb;

  import gmcn_pkg::*;

  localparam int MAX_COLS        = MAX_COLUMNS_DEF;
  localparam int MAX_ROWS        = MAX_ROWS_DEF;
  localparam int PICK_KEYS       = DIRECT_KEYS_DEF;
  localparam int RESULT_LATENCY  = 10;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int LONG_HOLD       = 250;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 94;

  typedef enum logic [OP_W-1:0] {
    KEY_NONE    = gmcn_pkg::OP_NONE,
    KEY_LEFT    = gmcn_pkg::OP_LEFT,
    KEY_RIGHT   = gmcn_pkg::OP_RIGHT,
    KEY_UP      = gmcn_pkg::OP_UP,
    KEY_DOWN    = gmcn_pkg::OP_DOWN,
    KEY_CONFIRM = gmcn_pkg::OP_CONFIRM,
    KEY_ABORT   = gmcn_pkg::OP_ABORT,
    KEY_PICK    = gmcn_pkg::OP_PICK,
    KEY_JUMP    = gmcn_pkg::OP_JUMP,
    KEY_FIRST_SPARE = 4'd9,
    KEY_LAST_SPARE  = 4'd15
  } key_op_e;

  typedef enum logic [CODE_W-1:0] {
    RES_NONE   = gmcn_pkg::RC_NONE,
    RES_ABORT  = gmcn_pkg::RC_ABORT,
    RES_CHOSEN = gmcn_pkg::RC_CHOSEN
  } result_code_e;

  typedef enum logic [MODE_W-1:0] {
    SCROLL_STOP       = gmcn_pkg::SCR_STOP,
    SCROLL_WRAP       = gmcn_pkg::SCR_WRAP,
    SCROLL_CARRY      = gmcn_pkg::SCR_CARRY,
    SCROLL_CARRY_WRAP = gmcn_pkg::SCR_CARRY_WRAP
  } scroll_mode_e;

  typedef enum logic [APB_AW-1:0] {
    REG_COLUMNS = 4'h0,
    REG_ROWS    = 4'h4,
    REG_SCROLL  = 4'h8
  } reg_addr_e;

  typedef enum logic {
    ROW_KEY,
    ROW_CFG
  } plan_kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ITEM_W-1:0] chosen;
    logic [IDX_W-1:0]  index;
    logic [DIM_W-1:0]  column;
    logic [DIM_W-1:0]  row;
  } nav_result_t;

  typedef struct {
    plan_kind_e      kind;
    logic [OP_W-1:0] code;
    logic [NUM_W-1:0] number;
    bit              checked;
    nav_result_t     result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  gmcn_in_if  key_if ();
  gmcn_out_if result_if ();

  grid_menu_cursor_navigator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (key_if.sink),
    .out_ch     (result_if.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's registers and cursor.
  logic [DIM_W-1:0]  grid_columns = 4'd1;
  logic [DIM_W-1:0]  grid_rows = 4'd1;
  scroll_mode_e      scroll_rule = SCROLL_STOP;
  logic [DIM_W-1:0]  cursor_column = '0;
  logic [DIM_W-1:0]  cursor_row = '0;

  nav_result_t expected_results[$];
  plan_row_t   directed_plan[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic nav_result_t predict_step(input logic [OP_W-1:0] op,
                                               input logic [NUM_W-1:0] num);
    int nc;
    int nr;
    int x;
    int y;
    int code;
    int chosen;
    nav_result_t r;
    nc = (grid_columns == 0) ? 1 : ((grid_columns > MAX_COLS) ? MAX_COLS : grid_columns);
    nr = (grid_rows == 0) ? 1 : ((grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows);
    x = cursor_column;
    y = cursor_row;
    code = RES_NONE;
    chosen = 0;
    if (x > nc - 1) x = nc - 1;
    if (y > nr - 1) y = nr - 1;
    case (op)
      KEY_LEFT: begin
        if (x > 0) x--;
        else if (scroll_rule == SCROLL_WRAP) x = nc - 1;
        else if (scroll_rule == SCROLL_CARRY) begin
          if (y > 0) begin
            x = nc - 1;
            y--;
          end
        end else if (scroll_rule == SCROLL_CARRY_WRAP) begin
          x = nc - 1;
          y = (y > 0) ? y - 1 : nr - 1;
        end
      end
      KEY_RIGHT: begin
        if (x + 1 < nc) x++;
        else if (scroll_rule == SCROLL_WRAP) x = 0;
        else if (scroll_rule == SCROLL_CARRY) begin
          if (y + 1 < nr) begin
            x = 0;
            y++;
          end
        end else if (scroll_rule == SCROLL_CARRY_WRAP) begin
          x = 0;
          y = (y + 1 < nr) ? y + 1 : 0;
        end
      end
      KEY_UP: begin
        if (y > 0) y--;
        else if (scroll_rule == SCROLL_WRAP) y = nr - 1;
        else if (scroll_rule == SCROLL_CARRY) begin
          if (x > 0) begin
            y = nr - 1;
            x--;
          end
        end else if (scroll_rule == SCROLL_CARRY_WRAP) begin
          y = nr - 1;
          x = (x > 0) ? x - 1 : nc - 1;
        end
      end
      KEY_DOWN: begin
        if (y + 1 < nr) y++;
        else if (scroll_rule == SCROLL_WRAP) y = 0;
        else if (scroll_rule == SCROLL_CARRY) begin
          if (x + 1 < nc) begin
            y = 0;
            x++;
          end
        end else if (scroll_rule == SCROLL_CARRY_WRAP) begin
          y = 0;
          x = (x + 1 < nc) ? x + 1 : 0;
        end
      end
      KEY_CONFIRM: begin
        code = RES_CHOSEN;
        chosen = y * nc + x + 1;
      end
      KEY_ABORT: code = RES_ABORT;
      KEY_PICK: begin
        if (num >= 1 && num <= PICK_KEYS && num <= nc * nr) begin
          x = (num - 1) % nc;
          y = (num - 1) / nc;
          code = RES_CHOSEN;
          chosen = num;
        end
      end
      KEY_JUMP: begin
        if (num >= 1 && (num - 1) / nc < nr) begin
          x = (num - 1) % nc;
          y = (num - 1) / nc;
        end
      end
      default: ;
    endcase
    cursor_column = x[DIM_W-1:0];
    cursor_row = y[DIM_W-1:0];
    r.code = code[CODE_W-1:0];
    r.chosen = chosen[ITEM_W-1:0];
    r.index = IDX_W'(y * nc + x);
    r.column = x[DIM_W-1:0];
    r.row = y[DIM_W-1:0];
    return r;
  endfunction

  function automatic void plan_key(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num);
    plan_row_t row;
    row.kind = ROW_KEY;
    row.code = op;
    row.number = num;
    row.checked = 1'b0;
    row.result = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_checked(input logic [OP_W-1:0] op,
                                       input logic [NUM_W-1:0] num,
                                       input logic [CODE_W-1:0] code,
                                       input logic [ITEM_W-1:0] chosen,
                                       input logic [IDX_W-1:0] index,
                                       input logic [DIM_W-1:0] column,
                                       input logic [DIM_W-1:0] row_pos);
    plan_row_t row;
    row.kind = ROW_KEY;
    row.code = op;
    row.number = num;
    row.checked = 1'b1;
    row.result = '{code, chosen, index, column, row_pos};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input logic [APB_AW-1:0] addr, input logic [3:0] value);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.code = addr;
    row.number = {4'h0, value};
    row.checked = 1'b0;
    row.result = '0;
    directed_plan.push_back(row);
  endfunction

  task automatic offer_key(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num,
                           input bit checked, input nav_result_t typed_result);
    nav_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      key_if.valid <= 1'b0;
      @(posedge clk);
    end
    key_if.valid <= 1'b1;
    key_if.operation <= op;
    key_if.item_number <= num;
    do @(posedge clk); while (!key_if.ready);
    predicted = predict_step(op, num);
    expected_results.push_back(checked ? typed_result : predicted);
  endtask

  task automatic wait_drained();
    key_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [APB_AW-1:0] addr, input logic [3:0] value);
    logic [APB_DW-1:0] data;
    wait_drained();
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    data = {$urandom()};
    data[3:0] = value;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      REG_COLUMNS: grid_columns = data[DIM_W-1:0];
      REG_ROWS:    grid_rows = data[DIM_W-1:0];
      REG_SCROLL:  scroll_rule = scroll_mode_e'(data[MODE_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_served + 1;
      hold_left = LONG_HOLD;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    nav_result_t got;
    nav_result_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      got = '{result_if.result_code, result_if.chosen_item, result_if.cursor_index,
              result_if.cursor_column, result_if.cursor_row};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %p", got));
      end else begin
        want = expected_results.pop_front();
        if (got.code !== want.code)
          report_mismatch($sformatf("result_code %0d, expected %0d", got.code, want.code));
        if (got.chosen !== want.chosen)
          report_mismatch($sformatf("chosen_item %0d, expected %0d", got.chosen, want.chosen));
        if (got.index !== want.index)
          report_mismatch($sformatf("cursor_index %0d, expected %0d", got.index, want.index));
        if (got.column !== want.column)
          report_mismatch($sformatf("cursor_column %0d, expected %0d",
                                    got.column, want.column));
        if (got.row !== want.row)
          report_mismatch($sformatf("cursor_row %0d, expected %0d", got.row, want.row));
      end
    end
  end

  always @(posedge clk) begin
    if ((key_if.valid && key_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] num;
    int unsigned sel;
    logic [3:0] phase_columns[PHASES/2] = '{4'd9, 4'd1, 4'd15, 4'd0};
    logic [3:0] phase_rows[PHASES/2] = '{4'd9, 4'd9, 4'd0, 4'd15};

    key_if.valid <= 1'b0;
    key_if.operation <= '0;
    key_if.item_number <= '0;

    // After reset the grid is one cell, so the first rows can be read off directly.
    plan_checked(KEY_CONFIRM, 8'd0, RES_CHOSEN, 7'd1, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_ABORT, 8'hFF, RES_ABORT, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_NONE, 8'hFF, RES_NONE, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_LAST_SPARE, 8'hAA, RES_NONE, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_RIGHT, 8'h55, RES_NONE, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_PICK, 8'd1, RES_CHOSEN, 7'd1, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_PICK, 8'd2, RES_NONE, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_JUMP, 8'd0, RES_NONE, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_checked(KEY_JUMP, 8'd255, RES_NONE, 7'd0, 7'd0, 4'd0, 4'd0);
    plan_cfg(REG_COLUMNS, 4'd9);
    plan_cfg(REG_ROWS, 4'd9);
    plan_cfg(REG_SCROLL, 4'(SCROLL_CARRY_WRAP));
    plan_checked(KEY_JUMP, 8'd81, RES_NONE, 7'd0, 7'd80, 4'd8, 4'd8);
    plan_key(KEY_RIGHT, 8'd0);
    plan_key(KEY_LEFT, 8'd0);
    plan_key(KEY_DOWN, 8'd0);
    plan_key(KEY_UP, 8'd0);
    plan_checked(KEY_PICK, 8'd10, RES_CHOSEN, 7'd10, 7'd9, 4'd0, 4'd1);
    plan_key(KEY_PICK, 8'd11);
    plan_key(KEY_JUMP, 8'd82);
    plan_key(KEY_CONFIRM, 8'd0);
    plan_cfg(REG_COLUMNS, 4'd0);
    plan_cfg(REG_ROWS, 4'd15);
    plan_cfg(REG_SCROLL, 4'(SCROLL_WRAP));
    plan_key(KEY_UP, 8'd0);
    plan_key(KEY_LEFT, 8'd0);
    plan_key(KEY_CONFIRM, 8'd0);
    plan_cfg(REG_COLUMNS, 4'd15);
    plan_cfg(REG_ROWS, 4'd0);
    plan_cfg(REG_SCROLL, 4'(SCROLL_CARRY));
    plan_key(KEY_DOWN, 8'd0);
    plan_key(KEY_LEFT, 8'd0);
    plan_key(KEY_JUMP, 8'd9);
    plan_key(KEY_RIGHT, 8'd0);
    plan_key(KEY_CONFIRM, 8'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG)
        write_register(directed_plan[i].code, directed_plan[i].number[3:0]);
      else
        offer_key(directed_plan[i].code, directed_plan[i].number,
                  directed_plan[i].checked, directed_plan[i].result);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < PHASES / 2) begin
        write_register(REG_COLUMNS, phase_columns[ph]);
        write_register(REG_ROWS, phase_rows[ph]);
        write_register(REG_SCROLL, 4'(ph));
      end else begin
        write_register(REG_COLUMNS, 4'($urandom_range(0, 15)));
        write_register(REG_ROWS, 4'($urandom_range(0, 15)));
        write_register(REG_SCROLL, 4'($urandom_range(0, 3)));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 20) hold_requests = hold_requests + 1;
        if (ph == 3 && n == 40) wait_drained();
        sel = $urandom_range(99);
        num = 8'($urandom_range(0, 255));
        if (sel < 50) begin
          op = 4'($urandom_range(KEY_LEFT, KEY_DOWN));
        end else if (sel < 60) begin
          op = KEY_CONFIRM;
        end else if (sel < 64) begin
          op = KEY_ABORT;
        end else if (sel < 77) begin
          op = KEY_PICK;
          if ($urandom_range(3) != 0) num = 8'($urandom_range(0, PICK_KEYS + 1));
        end else if (sel < 90) begin
          op = KEY_JUMP;
          if ($urandom_range(3) != 0) num = 8'($urandom_range(0, MAX_COLS * MAX_ROWS + 2));
        end else if ($urandom_range(7) == 0) begin
          op = KEY_NONE;
        end else begin
          op = 4'($urandom_range(KEY_FIRST_SPARE, KEY_LAST_SPARE));
        end
        offer_key(op, num, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (RESULT_LATENCY * 2) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
